[src/bcmp_pkg.sv]
// bcmp_pkg: shared types, register indexes and constants of the barometer compensation block
// no dependencies; imported by barometer_compensation_top, bcmp_front, bcmp_back and the testbench files
package bcmp_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_AC1   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AC2   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AC3   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AC4   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AC5   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_AC6   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_B1_B2 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_MC_MD = 3'd7;

   // temperature divide: |mc << 11| stays below 2^27
   localparam int MC_SHIFT = 11;
   localparam int DIV_T_W  = 27;
   localparam int DIV_P_W  = 32;

   // compensation constants
   localparam logic [31:0] TEMP_OFFSET = 32'd4000;
   localparam logic [31:0] C_3038      = 32'd3038;
   localparam logic [31:0] C_NEG7357   = 32'hFFFF_E343;
   localparam logic [31:0] C_3791      = 32'd3791;
   localparam logic [31:0] C_50000     = 32'd50000;
   localparam logic [31:0] C_32768     = 32'd32768;

   // calibration coefficients as held in the registers
   typedef struct packed {
      logic [15:0] ac1;
      logic [15:0] ac2;
      logic [15:0] ac3;
      logic [15:0] ac4;
      logic [15:0] ac5;
      logic [15:0] ac6;
      logic [15:0] b1;
      logic [15:0] b2;
      logic [15:0] mc;
      logic [15:0] md;
   } coef_type;

   // item between front and back
   typedef struct packed {
      logic [31:0] x1;
      logic [15:0] up;
   } mid_item_type;

   // result item
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] pres;
      logic        status;
   } rsp_item_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // arithmetic right shift, called with constant amounts
   function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
      return 32'($signed(v) >>> s);
   endfunction

endpackage

[src/barometer_compensation_top.sv]
// barometer_compensation_top: coefficient registers, front stage, queues and back pipeline
// depends on bcmp_pkg, bcmp_fifo, bcmp_front, bcmp_back
//
//   channel   ports                                   transfer when
//   input     push, full, req_raw_*                   push && !full
//   result    empty, pop, rsp_*                       pop && !empty
//   config    csr_wr_en, csr_index, csr_data          csr_wr_en
//
// one reading pair per cycle sustained while results are popped; each reading pair passes through
// the two bit-per-stage dividers (27 and 32 stages) plus 17 arithmetic and queue stages on the
// way to its result transfer
// synchronous active-high reset clears coefficient registers, valid bits and queue pointers
// a full result queue stalls the back pipeline; the middle queue then fills and
// full rises once the front stage holds an item as well
module barometer_compensation_top #(
   parameter int MID_DEPTH = 4,
   parameter int OUT_DEPTH = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [15:0]                      req_raw_temperature,
   input  logic [15:0]                      req_raw_pressure,
   output logic                             empty,
   input  logic                             pop,
   output logic [31:0]                      rsp_temperature_decidegrees,
   output logic [31:0]                      rsp_pressure_pascal,
   output logic                             rsp_status,
   input  logic                             csr_wr_en,
   input  logic [bcmp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bcmp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bcmp_pkg::*;

   coef_type     coef_ff, coef_in;
   logic         mid_push, mid_full, mid_pop, mid_empty;
   mid_item_type mid_wr, mid_rd;
   logic         out_push, out_full;
   rsp_item_type out_wr, out_rd;

   // coefficient registers
   always_comb begin
      coef_in = coef_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AC1:   coef_in.ac1 = csr_data[15:0];
            CSR_AC2:   coef_in.ac2 = csr_data[15:0];
            CSR_AC3:   coef_in.ac3 = csr_data[15:0];
            CSR_AC4:   coef_in.ac4 = csr_data[15:0];
            CSR_AC5:   coef_in.ac5 = csr_data[15:0];
            CSR_AC6:   coef_in.ac6 = csr_data[15:0];
            CSR_B1_B2: begin
               coef_in.b1 = csr_data[31:16];
               coef_in.b2 = csr_data[15:0];
            end
            CSR_MC_MD: begin
               coef_in.mc = csr_data[31:16];
               coef_in.md = csr_data[15:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // front stage
   bcmp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .coef            (coef_ff),
      .push            (push),
      .full            (full),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .mid_push        (mid_push),
      .mid_full        (mid_full),
      .mid_item        (mid_wr)
   );

   // queue between front and back
   bcmp_fifo #(
      .DEPTH (MID_DEPTH),
      .WIDTH ($bits(mid_item_type))
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   // back pipeline
   bcmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .mid_empty (mid_empty),
      .mid_item  (mid_rd),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_wr)
   );

   // result queue
   bcmp_fifo #(
      .DEPTH (OUT_DEPTH),
      .WIDTH ($bits(rsp_item_type))
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_wr),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_rd),
      .empty   (empty)
   );

   assign rsp_temperature_decidegrees = out_rd.temp;
   assign rsp_pressure_pascal         = out_rd.pres;
   assign rsp_status                  = out_rd.status;

endmodule

[src/bcmp_fifo.sv]
// bcmp_fifo: small register queue with push/pop handshake
// no package dependencies; used between front and back and at the result side
module bcmp_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status and transfers
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[src/bcmp_front.sv]
// bcmp_front: accepts raw reading pairs and forms the first temperature term x1
// depends on bcmp_pkg; feeds the queue in front of bcmp_back
module bcmp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  bcmp_pkg::coef_type     coef,
   input  logic                   push,
   output logic                   full,
   input  logic [15:0]            raw_temperature,
   input  logic [15:0]            raw_pressure,
   output logic                   mid_push,
   input  logic                   mid_full,
   output bcmp_pkg::mid_item_type mid_item
);
   import bcmp_pkg::*;

   logic         vld_ff, vld_in;
   mid_item_type item_ff, item_in;
   logic         take;
   logic [31:0]  diff, prod;

   // handshake: the stage holds only while the queue is full
   assign full     = vld_ff && mid_full;
   assign take     = push && !full;
   assign mid_push = vld_ff && !mid_full;
   assign mid_item = item_ff;

   // x1 = ((ut - ac6) * ac5) >> 15
   always_comb begin
      diff       = {16'b0, raw_temperature} - {16'b0, coef.ac6};
      prod       = diff * {16'b0, coef.ac5};
      item_in.x1 = asr(prod, 15);
      item_in.up = raw_pressure;
      vld_in     = take || (vld_ff && mid_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

[src/bcmp_div.sv]
// bcmp_div: pipelined unsigned restoring divider, one quotient bit per stage
// no package dependencies; instantiated twice by bcmp_back
module bcmp_div #(
   parameter int NUM_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [31:0]       in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [NUM_W];
   logic [31:0]       rem_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [31:0]       den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              src_vld;
      logic [31:0]       src_rem, src_den;
      logic [NUM_W-1:0]  src_nq;
      logic [SIDE_W-1:0] src_side;
      logic [32:0]       shifted, diff;
      logic              ge;

      // stage source: ports for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_rem  = '0;
         assign src_nq   = in_num;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k-1];
         assign src_rem  = rem_ff[k-1];
         assign src_nq   = nq_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      // trial subtract of the shifted remainder
      assign shifted = {src_rem, src_nq[NUM_W-1]};
      assign diff    = shifted - {1'b0, src_den};
      assign ge      = !diff[32];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge ? diff[31:0] : shifted[31:0];
            nq_ff[k]   <= {src_nq[NUM_W-2:0], ge};
            den_ff[k]  <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign out_quo  = nq_ff[NUM_W-1];
   assign out_side = side_ff[NUM_W-1];

endmodule

[src/bcmp_back.sv]
// bcmp_back: temperature divide, pressure polynomial, pressure divide and final correction
// depends on bcmp_pkg and bcmp_div; pops the middle queue, pushes the result queue
module bcmp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bcmp_pkg::coef_type     coef,
   input  logic                   mid_empty,
   input  bcmp_pkg::mid_item_type mid_item,
   output logic                   mid_pop,
   input  logic                   out_full,
   output logic                   out_push,
   output bcmp_pkg::rsp_item_type out_item
);
   import bcmp_pkg::*;

   localparam int C_STAGES = 10;
   localparam int D_STAGES = 3;

   typedef struct packed {
      logic [31:0] x1;
      logic [15:0] up;
      logic        neg;
      logic        bad;
   } div1_side_type;

   typedef struct packed {
      logic [31:0] temp;
      logic        scl;
      logic        bad;
   } div2_side_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [15:0] up;
      logic [31:0] b5;
      logic [31:0] b6;
      logic [31:0] psq;
      logic [31:0] sq;
      logic [31:0] pa2;
      logic [31:0] pb2;
      logic [31:0] pb1;
      logic [31:0] x3;
      logic [31:0] b3;
      logic [31:0] pa3;
      logic [31:0] x3b;
      logic [31:0] b7;
      logic [31:0] pb4;
      logic [31:0] b4;
      logic [31:0] num;
      logic        scl;
      logic        bad;
   } poly_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] p;
      logic [31:0] pt;
      logic [31:0] pm;
      logic [31:0] pn;
      logic        bad;
   } corr_type;

   logic               adv;
   logic               b0_vld_ff;
   logic [DIV_T_W-1:0] b0_num_ff;
   logic [31:0]        b0_den_ff;
   div1_side_type      b0_side_ff;
   logic [31:0]        den, nmc, an, ad;

   logic               q1_vld;
   logic [DIV_T_W-1:0] q1;
   div1_side_type      s1;

   poly_type           c_ff [1:C_STAGES];
   poly_type           c_in [1:C_STAGES];
   logic               c_vld_ff [1:C_STAGES];
   logic [31:0]        v3;

   div2_side_type      s2_in, s2;
   logic               q2_vld;
   logic [DIV_P_W-1:0] q2;

   corr_type           d_ff [1:D_STAGES];
   corr_type           d_in [1:D_STAGES];
   logic               d_vld_ff [1:D_STAGES];
   logic [31:0]        corr_sum, pres;

   // the whole pipe moves while the result queue has room
   assign adv      = !out_full;
   assign mid_pop  = adv && !mid_empty;
   assign out_push = adv && d_vld_ff[D_STAGES];

   // divider setup: den = x1 + md, numerator mc << 11, signs split off
   always_comb begin
      den = mid_item.x1 + sx16(coef.md);
      nmc = sx16(coef.mc) << MC_SHIFT;
      an  = nmc[31] ? 32'(0) - nmc : nmc;
      ad  = den[31] ? 32'(0) - den : den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_vld_ff <= 1'b0;
      end else if (adv) begin
         b0_vld_ff <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b0_num_ff      <= an[DIV_T_W-1:0];
         b0_den_ff      <= ad;
         b0_side_ff.x1  <= mid_item.x1;
         b0_side_ff.up  <= mid_item.up;
         b0_side_ff.neg <= nmc[31] ^ den[31];
         b0_side_ff.bad <= (den == '0);
      end
   end

   // temperature divide
   bcmp_div #(
      .NUM_W  (DIV_T_W),
      .SIDE_W ($bits(div1_side_type))
   ) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (b0_vld_ff),
      .in_num   (b0_num_ff),
      .in_den   (b0_den_ff),
      .in_side  (b0_side_ff),
      .out_vld  (q1_vld),
      .out_quo  (q1),
      .out_side (s1)
   );

   // b5, temperature and the pressure polynomial, at most one multiply per stage
   always_comb begin
      v3 = '0;
      c_in[1]     = '0;
      c_in[1].up  = s1.up;
      c_in[1].bad = s1.bad;
      c_in[1].b5  = s1.x1 + (s1.neg ? 32'(0) - 32'(q1) : 32'(q1));

      c_in[2]      = c_ff[1];
      c_in[2].temp = asr(c_ff[1].b5 + 32'd8, 4);
      c_in[2].b6   = c_ff[1].b5 - TEMP_OFFSET;

      c_in[3]     = c_ff[2];
      c_in[3].psq = c_ff[2].b6 * c_ff[2].b6;

      c_in[4]     = c_ff[3];
      c_in[4].sq  = asr(c_ff[3].psq, 12);
      c_in[4].pa2 = sx16(coef.ac2) * c_ff[3].b6;

      c_in[5]     = c_ff[4];
      c_in[5].pb2 = sx16(coef.b2) * c_ff[4].sq;

      c_in[6]     = c_ff[5];
      c_in[6].x3  = asr(c_ff[5].pb2, 11) + asr(c_ff[5].pa2, 11);
      c_in[6].pb1 = sx16(coef.b1) * c_ff[5].sq;

      // b3 = (4 * ac1 + x3 + 2) / 4, rounded toward zero
      v3          = (sx16(coef.ac1) << 2) + c_ff[6].x3 + 32'd2;
      c_in[7]     = c_ff[6];
      c_in[7].b3  = asr(v3 + (v3[31] ? 32'd3 : 32'd0), 2);
      c_in[7].pa3 = sx16(coef.ac3) * c_ff[6].b6;

      c_in[8]     = c_ff[7];
      c_in[8].x3b = asr(asr(c_ff[7].pa3, 13) + asr(c_ff[7].pb1, 16) + 32'd2, 2);
      c_in[8].b7  = (32'(c_ff[7].up) - c_ff[7].b3) * C_50000;

      c_in[9]     = c_ff[8];
      c_in[9].pb4 = 32'(coef.ac4) * (c_ff[8].x3b + C_32768);

      // b4 and the divide setup; large b7 divides first and doubles after
      c_in[10]     = c_ff[9];
      c_in[10].b4  = c_ff[9].pb4 >> 15;
      c_in[10].bad = c_ff[9].bad || (c_in[10].b4 == '0);
      c_in[10].scl = c_ff[9].b7[31];
      c_in[10].num = c_ff[9].b7[31] ? c_ff[9].b7 : {c_ff[9].b7[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= C_STAGES; k++) begin
            c_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         c_vld_ff[1] <= q1_vld;
         for (int k = 2; k <= C_STAGES; k++) begin
            c_vld_ff[k] <= c_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= C_STAGES; k++) begin
            c_ff[k] <= c_in[k];
         end
      end
   end

   // pressure divide
   assign s2_in.temp = c_ff[C_STAGES].temp;
   assign s2_in.scl  = c_ff[C_STAGES].scl;
   assign s2_in.bad  = c_ff[C_STAGES].bad;

   bcmp_div #(
      .NUM_W  (DIV_P_W),
      .SIDE_W ($bits(div2_side_type))
   ) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (c_vld_ff[C_STAGES]),
      .in_num   (c_ff[C_STAGES].num),
      .in_den   (c_ff[C_STAGES].b4),
      .in_side  (s2_in),
      .out_vld  (q2_vld),
      .out_quo  (q2),
      .out_side (s2)
   );

   // final pressure correction
   always_comb begin
      d_in[1]      = '0;
      d_in[1].temp = s2.temp;
      d_in[1].bad  = s2.bad;
      d_in[1].p    = s2.scl ? {q2[30:0], 1'b0} : q2;

      d_in[2]    = d_ff[1];
      d_in[2].pt = asr(d_ff[1].p, 8) * asr(d_ff[1].p, 8);

      d_in[3]    = d_ff[2];
      d_in[3].pm = d_ff[2].pt * C_3038;
      d_in[3].pn = d_ff[2].p * C_NEG7357;

      corr_sum = asr(d_ff[3].pm, 16) + asr(d_ff[3].pn, 16) + C_3791;
      pres     = d_ff[3].p + asr(corr_sum, 4);

      out_item.temp   = d_ff[3].bad ? '0 : d_ff[3].temp;
      out_item.pres   = d_ff[3].bad ? '0 : pres;
      out_item.status = d_ff[3].bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= D_STAGES; k++) begin
            d_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         d_vld_ff[1] <= q2_vld;
         for (int k = 2; k <= D_STAGES; k++) begin
            d_vld_ff[k] <= d_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 1; k <= D_STAGES; k++) begin
            d_ff[k] <= d_in[k];
         end
      end
   end

   // a flagged result carries zero values
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_push && out_item.status |-> out_item.temp == '0 && out_item.pres == '0)
      else $error("flagged result with nonzero values");

   // a stalled pipe keeps its last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(d_vld_ff[D_STAGES]))
      else $error("last stage moved during stall");

   // no pop from an empty middle queue or while the pipe is stalled
   a_pop_guard: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty && !out_full)
      else $error("middle queue popped while empty or stalled");

endmodule

[tb/bcmp_checker.sv]
// bcmp_checker: watches the input, result and register channels of the compensation block,
// predicts every result from its own coefficient copy and compares field by field
// depends on bcmp_pkg for the register indexes and on the port widths of barometer_compensation_top
module bcmp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [15:0] req_raw_temperature,
   input  logic [15:0] req_raw_pressure,
   input  logic        empty,
   input  logic        pop,
   input  logic [31:0] rsp_temperature_decidegrees,
   input  logic [31:0] rsp_pressure_pascal,
   input  logic        rsp_status,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import bcmp_pkg::*;

   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] pres;
      logic        status;
   } reading_t;

   // local copy of the calibration registers
   logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
   logic [31:0] b1b2, mcmd;
   reading_t    expected_readings[$];

   function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
      return 32'($signed(v) >>> s);
   endfunction

   function automatic logic [31:0] ext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // signed division truncating toward zero
   function automatic logic [31:0] div_trunc(input logic [31:0] n, input logic [31:0] d);
      logic [31:0] an, ad, q;
      an = n[31] ? -n : n;
      ad = d[31] ? -d : d;
      q  = an / ad;
      return (n[31] ^ d[31]) ? -q : q;
   endfunction

   function automatic reading_t compensate(input logic [15:0] ut16, input logic [15:0] up16);
      logic [31:0] ut, up, x1, x2, x3, den, b3, b4, b5, b6, b7, sq, p, t;
      reading_t    r;
      ut = {16'd0, ut16};
      up = {16'd0, up16};
      r  = '{temp: 32'd0, pres: 32'd0, status: 1'b1};
      // temperature
      x1  = shr_s((ut - {16'd0, ac6}) * {16'd0, ac5}, 15);
      den = x1 + ext16(mcmd[15:0]);
      if (den == 32'd0) return r;
      x2 = div_trunc(ext16(mcmd[31:16]) << 11, den);
      b5 = x1 + x2;
      r.temp = shr_s(b5 + 32'd8, 4);
      // pressure
      b6 = b5 - 32'd4000;
      sq = shr_s(b6 * b6, 12);
      x1 = shr_s(ext16(b1b2[15:0]) * sq, 11);
      x2 = shr_s(ext16(ac2) * b6, 11);
      x3 = x1 + x2;
      b3 = div_trunc(ext16(ac1) * 32'd4 + x3 + 32'd2, 32'd4);
      x1 = shr_s(ext16(ac3) * b6, 13);
      x2 = shr_s(ext16(b1b2[31:16]) * sq, 16);
      x3 = shr_s(x1 + x2 + 32'd2, 2);
      b4 = ({16'd0, ac4} * (x3 + 32'd32768)) >> 15;
      if (b4 == 32'd0) begin
         r.temp = 32'd0;
         return r;
      end
      b7 = (up - b3) * 32'd50000;
      p  = (b7 < 32'h8000_0000) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
      t  = shr_s(p, 8);
      x1 = shr_s((t * t) * 32'd3038, 16);
      x2 = shr_s(32'hFFFF_E343 * p, 16);
      r.pres   = p + shr_s(x1 + x2 + 32'd3791, 4);
      r.status = 1'b0;
      return r;
   endfunction

   assign pending = expected_readings.size();

   // register writes, input transfers and result transfers
   always @(posedge clock) begin
      reading_t want;
      if (reset) begin
         {ac1, ac2, ac3, ac4, ac5, ac6} <= '0;
         b1b2 <= '0;
         mcmd <= '0;
         expected_readings.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AC1:   ac1  <= csr_data[15:0];
               CSR_AC2:   ac2  <= csr_data[15:0];
               CSR_AC3:   ac3  <= csr_data[15:0];
               CSR_AC4:   ac4  <= csr_data[15:0];
               CSR_AC5:   ac5  <= csr_data[15:0];
               CSR_AC6:   ac6  <= csr_data[15:0];
               CSR_B1_B2: b1b2 <= csr_data;
               CSR_MC_MD: mcmd <= csr_data;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: result transfer with nothing expected: temp %h pres %h status %b",
                        $time, rsp_temperature_decidegrees, rsp_pressure_pascal, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_readings.pop_front();
               if (want.temp !== rsp_temperature_decidegrees ||
                   want.pres !== rsp_pressure_pascal || want.status !== rsp_status) begin
                  $display("%0t: mismatch temp exp %h act %h, pres exp %h act %h, status exp %b act %b",
                           $time, want.temp, rsp_temperature_decidegrees, want.pres,
                           rsp_pressure_pascal, want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (push && !full)
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure));
      end
   end
endmodule

[tb/testbench.sv]
// testbench: stimulus, register phases and verdict for barometer_compensation_top
// depends on bcmp_pkg, the block's sources and bcmp_checker
module testbench;
   import bcmp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [15:0] req_raw_temperature = '0;
   logic [15:0] req_raw_pressure = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_temperature_decidegrees;
   logic [31:0] rsp_pressure_pascal;
   logic        rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          hold_left = 0;

   always #10 clock = ~clock;

   barometer_compensation_top u_top (.*);

   bcmp_checker u_checker (.*);

   // result side: random pop with short and long gaps, one long hold-off to fill the block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 2500) begin
         hold_left <= 400;
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else if ($urandom_range(0, 999) == 0) begin
         hold_left <= $urandom_range(20, 120);
         pop <= 1'b0;
      end else if (cycle_count % 1000 < 300) begin
         pop <= 1'b1;
      end else begin
         pop <= ($urandom_range(0, 9) < 7);
      end
   end

   // write all coefficient registers back to back
   task automatic load_coefs(input logic [31:0] c[8]);
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= i[2:0];
         csr_data  <= c[i];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one reading pair transfer, then a random gap
   task automatic send_reading(input logic [15:0] ut, input logic [15:0] up);
      int gap, pick;
      pick = $urandom_range(0, 99);
      gap  = (pick < 60 || cycle_count % 1000 < 300) ? 0 :
             (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      push <= 1'b1;
      req_raw_temperature <= ut;
      req_raw_pressure    <= up;
      do @(posedge clock); while (full);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain;
      @(posedge clock);
      push <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (120) @(posedge clock);
   endtask

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++)
         send_reading(16'($urandom()), 16'($urandom()));
   endtask

   task automatic send_corners;
      logic [15:0] uts[4] = '{16'h0000, 16'hFFFF, 16'd27898, 16'h0001};
      logic [15:0] ups[3] = '{16'h0000, 16'hFFFF, 16'd23843};
      foreach (uts[i])
         foreach (ups[j])
            send_reading(uts[i], ups[j]);
   endtask

   initial begin
      logic [31:0] typical[8] = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd32757,
                                  32'd23153, {16'd6190, 16'd4}, {16'hDDF9, 16'd2868}};
      logic [31:0] c[8];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: temperature divisor is zero
      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'hFFFF);
      drain();

      // typical calibration
      load_coefs(typical);
      send_corners();
      send_random(400);
      drain();

      // maximum coefficients
      c = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
            32'h7FFF_7FFF, 32'h7FFF_7FFF};
      load_coefs(c);
      send_corners();
      send_random(250);
      drain();

      // minimum coefficients
      c = '{32'h8000, 32'h8000, 32'h8000, 32'h0, 32'h0, 32'h0, 32'h8000_8000, 32'h8000_8000};
      load_coefs(c);
      send_random(250);
      drain();

      // zero pressure scale: pressure divisor is zero
      c = typical;
      c[3] = 32'd0;
      load_coefs(c);
      send_reading(16'd27898, 16'd23843);
      send_random(150);
      drain();

      // random calibrations
      for (int k = 0; k < 4; k++) begin
         foreach (c[i]) c[i] = $urandom();
         load_coefs(c);
         send_random(225);
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

[sim.f]
src/bcmp_pkg.sv
src/bcmp_fifo.sv
src/bcmp_front.sv
src/bcmp_div.sv
src/bcmp_back.sv
src/barometer_compensation_top.sv
tb/bcmp_checker.sv
tb/testbench.sv
